FILE: design/crct_pkg.sv
// Shared types and constants for the Catmull-Rom curve tessellator.
package crct_pkg;

  localparam int COORD_W     = 32;
  // Working width of the Horner evaluation; coefficients and partial sums stay below 2^36.
  localparam int VAL_W       = 38;
  localparam int T_STEP_W    = 17;
  localparam logic [T_STEP_W-1:0] T_STEP_RESET = 17'd3277;
  localparam int NUM_AXES    = 3;
  localparam int NUM_SLOTS   = 4;
  localparam int VCNT_W      = 6;
  localparam logic [VCNT_W-1:0] VCNT_LAST = 6'd63;
  localparam int HELD_W      = 3;
  localparam logic [HELD_W-1:0] HELD_FULL = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COEF,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic shift_win;
    logic load_coef;
    logic issue;
    logic issue_last;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic adv;
  } status_t;

endpackage

FILE: design/crct_ctrl.sv
// Controller: window fill count, step register and vertex sequencing over t.
module crct_ctrl #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          curve_start,
  input  logic                          cfg_wr_en,
  input  logic [crct_pkg::T_STEP_W-1:0] cfg_wr_data,
  input  crct_pkg::status_t             stat,
  output crct_pkg::cmd_t                cmd,
  output logic [T_FRAC_BITS:0]          issue_t
);

  localparam int TW = T_FRAC_BITS + 1;
  localparam int SW = ((TW > crct_pkg::T_STEP_W) ? TW : crct_pkg::T_STEP_W) + 1;
  localparam logic [SW-1:0] ONE_S = SW'(1) << T_FRAC_BITS;
  localparam logic [TW-1:0] ONE_T = TW'(1) << T_FRAC_BITS;

  crct_pkg::state_t                   state, state_next;
  logic [crct_pkg::T_STEP_W-1:0]      t_step;
  logic [crct_pkg::HELD_W-1:0]        points_held, points_held_next;
  logic [crct_pkg::HELD_W-1:0]        held_base;
  logic [TW-1:0]                      current_t;
  logic [crct_pkg::VCNT_W-1:0]        vert_cnt;
  logic [SW-1:0]                      t_sum;
  logic                               accept;
  logic                               run_last;

  assign accept  = (state == crct_pkg::ST_IDLE) && in_valid && !stat.busy;
  assign issue_t = current_t;

  always_comb begin
    held_base = curve_start ? '0 : points_held;
    if (held_base < crct_pkg::HELD_FULL) begin
      points_held_next = held_base + crct_pkg::HELD_W'(1);
    end else begin
      points_held_next = held_base;
    end
  end

  always_comb begin
    t_sum    = SW'(current_t) + SW'(t_step);
    run_last = (t_sum > ONE_S) || (vert_cnt == crct_pkg::VCNT_LAST);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      crct_pkg::ST_IDLE: begin
        if (accept && (points_held_next == crct_pkg::HELD_FULL)) begin
          state_next = crct_pkg::ST_COEF;
        end
      end
      crct_pkg::ST_COEF: begin
        state_next = crct_pkg::ST_RUN;
      end
      crct_pkg::ST_RUN: begin
        if (stat.adv && run_last) begin
          state_next = crct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = crct_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.shift_win  = 1'b0;
    cmd.load_coef  = 1'b0;
    cmd.issue      = 1'b0;
    cmd.issue_last = run_last;
    unique case (state)
      crct_pkg::ST_IDLE: begin
        in_ready      = !stat.busy;
        cmd.shift_win = accept;
      end
      crct_pkg::ST_COEF: begin
        cmd.load_coef = 1'b1;
      end
      crct_pkg::ST_RUN: begin
        cmd.issue = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= crct_pkg::ST_IDLE;
      t_step      <= crct_pkg::T_STEP_RESET;
      points_held <= '0;
      current_t   <= '0;
      vert_cnt    <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        t_step <= cfg_wr_data;
      end
      if (accept) begin
        points_held <= points_held_next;
      end
      if ((state == crct_pkg::ST_RUN) && stat.adv) begin
        if (run_last) begin
          current_t <= '0;
          vert_cnt  <= '0;
        end else begin
          current_t <= t_sum[TW-1:0];
          vert_cnt  <= vert_cnt + crct_pkg::VCNT_W'(1);
        end
      end
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    points_held <= crct_pkg::HELD_FULL)
    else $error("points_held above four");

  a_t_bound: assert property (@(posedge clk) disable iff (rst)
    (state == crct_pkg::ST_RUN) |-> (current_t <= ONE_T))
    else $error("t beyond one while issuing");

  a_coef_full: assert property (@(posedge clk) disable iff (rst)
    (state == crct_pkg::ST_COEF) |-> (points_held == crct_pkg::HELD_FULL))
    else $error("segment started without a full window");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && cmd.issue_last && stat.adv) |=> (state == crct_pkg::ST_IDLE))
    else $error("run continued past its last vertex");

endmodule

FILE: design/crct_dp.sv
// Datapath: point window, blend coefficients, three-stage Horner pipeline and output register.
module crct_dp #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  crct_pkg::cmd_t                      cmd,
  input  logic [T_FRAC_BITS:0]                issue_t,
  input  logic signed [crct_pkg::COORD_W-1:0] pt_x,
  input  logic signed [crct_pkg::COORD_W-1:0] pt_y,
  input  logic signed [crct_pkg::COORD_W-1:0] pt_z,
  output crct_pkg::status_t                   stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [3*crct_pkg::COORD_W-1:0]      out_data,
  output logic                                out_last
);

  localparam int TW = T_FRAC_BITS + 1;
  localparam int VW = crct_pkg::VAL_W;
  localparam int PW = VW + TW + 1;
  localparam int CW = crct_pkg::COORD_W;
  localparam int NA = crct_pkg::NUM_AXES;
  localparam int NS = crct_pkg::NUM_SLOTS;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (T_FRAC_BITS - 1);

  // Product with t, rounded to nearest with halves toward plus infinity.
  function automatic logic signed [VW-1:0] mul_t(input logic signed [VW-1:0] v,
                                                 input logic [TW-1:0] t);
    logic signed [PW-1:0] p;
    p = v * $signed({1'b0, t});
    p = p + HALF;
    return VW'(p >>> T_FRAC_BITS);
  endfunction

  function automatic logic [CW-1:0] finish(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] h;
    h = (v + VW'(1)) >>> 1;
    if (h[VW-1:CW-1] == '0 || h[VW-1:CW-1] == '1) begin
      return h[CW-1:0];
    end else if (h[VW-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  logic signed [CW-1:0] win [NS][NA];
  logic signed [VW-1:0] a0 [NA];
  logic signed [VW-1:0] a1 [NA];
  logic signed [VW-1:0] a2 [NA];
  logic signed [VW-1:0] a3 [NA];
  logic signed [VW-1:0] v1 [NA];
  logic signed [VW-1:0] v2 [NA];
  logic signed [VW-1:0] v3 [NA];
  logic [TW-1:0]        t1, t2;
  logic                 s1_valid, s2_valid, s3_valid;
  logic                 last1, last2, last3;
  logic signed [CW-1:0] pt_in [NA];
  logic                 adv;

  assign pt_in[0] = pt_x;
  assign pt_in[1] = pt_y;
  assign pt_in[2] = pt_z;

  assign adv       = !out_valid || out_ready;
  assign stat.adv  = adv;
  assign stat.busy = s1_valid || s2_valid || s3_valid;

  always_ff @(posedge clk) begin
    if (cmd.shift_win) begin
      for (int a = 0; a < NA; a++) begin
        for (int s = 0; s < NS - 1; s++) begin
          win[s][a] <= win[s+1][a];
        end
        win[NS-1][a] <= pt_in[a];
      end
    end
  end

  // Integer coefficients are twice the standard blend coefficients.
  always_ff @(posedge clk) begin
    if (cmd.load_coef) begin
      for (int a = 0; a < NA; a++) begin
        a0[a] <= VW'(win[1][a]) <<< 1;
        a1[a] <= VW'(win[2][a]) - VW'(win[0][a]);
        a2[a] <= (VW'(win[0][a]) <<< 1) - (VW'(win[1][a]) <<< 2) - VW'(win[1][a])
                 + (VW'(win[2][a]) <<< 2) - VW'(win[3][a]);
        a3[a] <= VW'(win[3][a]) - VW'(win[0][a]) + (VW'(win[1][a]) <<< 1)
                 + VW'(win[1][a]) - (VW'(win[2][a]) <<< 1) - VW'(win[2][a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1    <= issue_t;
      t2    <= t1;
      last1 <= cmd.issue_last;
      last2 <= last1;
      last3 <= last2;
      for (int a = 0; a < NA; a++) begin
        v1[a] <= mul_t(a3[a], issue_t) + a2[a];
        v2[a] <= mul_t(v1[a], t1) + a1[a];
        v3[a] <= mul_t(v2[a], t2) + a0[a];
      end
      out_last <= last3;
      for (int a = 0; a < NA; a++) begin
        out_data[a*CW +: CW] <= finish(v3[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= cmd.issue;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

endmodule

FILE: design/catmull_rom_curve_tessellator_core.sv
// A point that completes the window moves the controller from ST_IDLE through ST_COEF to ST_RUN;
// vertices pass the three Horner stages and the output register. Throughput: one vertex per
// cycle while the sink takes them. Such a point yields N vertices, N = floor(1/t_step) + 1
// capped at 64 (20 at the reset step); the window shifts again only once the three multiply
// stages of the Horner pipeline drain. A point that leaves fewer than four is only shifted in.
// Reset empties the window count, the pipeline and the output, and sets t_step to 3277.
module catmull_rom_curve_tessellator_core #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [95:0]                   s_axis_tdata,  // point_x, point_y, point_z
  input  logic                          s_axis_tuser,  // curve_start
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [95:0]                   m_axis_tdata,  // vertex_x, vertex_y, vertex_z
  output logic                          m_axis_tlast,  // segment_last
  input  logic                          cfg_wr_en,
  input  logic [crct_pkg::T_STEP_W-1:0] cfg_wr_data
);

  localparam int CW = crct_pkg::COORD_W;

  crct_pkg::cmd_t       cmd;
  crct_pkg::status_t    stat;
  logic [T_FRAC_BITS:0] issue_t;

  crct_ctrl #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .curve_start(s_axis_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .stat       (stat),
    .cmd        (cmd),
    .issue_t    (issue_t)
  );

  crct_dp #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .issue_t  (issue_t),
    .pt_x     (s_axis_tdata[CW-1:0]),
    .pt_y     (s_axis_tdata[2*CW-1:CW]),
    .pt_z     (s_axis_tdata[3*CW-1:2*CW]),
    .stat     (stat),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata),
    .out_last (m_axis_tlast)
  );

endmodule

FILE: dv/tb_catmull_rom_curve_tessellator_core.sv
// Self-checking testbench for the Catmull-Rom curve tessellator core.
`timescale 1ns / 100ps

module tb_catmull_rom_curve_tessellator_core;

  localparam int T_FRAC = 16;
  localparam longint T_ONE = longint'(1) << T_FRAC;
  localparam int MAX_VERTS = 64;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD = 400;
  localparam int NUM_PHASES = 6;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
  } vertex_t;

  // Holds a private copy of the window and step, and the vertices still owed by the block.
  class vertex_scoreboard;
    logic [crct_pkg::T_STEP_W-1:0] t_step;
    longint                        win[12];
    int                            held;
    vertex_t                       expected_q[$];
    int                            errors;

    function new();
      t_step = crct_pkg::T_STEP_RESET;
      held = 0;
      errors = 0;
      foreach (win[i]) win[i] = 0;
    endfunction

    function void report(string field, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t mismatch on %s: got %h, expected %h", $time, field, got, want);
    endfunction

    // Product with t, rounded to nearest with halves going up (arithmetic shift is a floor).
    function longint scale_by_t(longint v, longint t);
      return (v * t + (longint'(1) << (T_FRAC - 1))) >>> T_FRAC;
    endfunction

    function logic [31:0] blend_axis(int axis, longint t);
      longint p0, p1, p2, p3, acc;
      p0 = win[axis];
      p1 = win[3 + axis];
      p2 = win[6 + axis];
      p3 = win[9 + axis];
      acc = -p0 + 3 * p1 - 3 * p2 + p3;
      acc = scale_by_t(acc, t) + (2 * p0 - 5 * p1 + 4 * p2 - p3);
      acc = scale_by_t(acc, t) + (p2 - p0);
      acc = scale_by_t(acc, t) + 2 * p1;
      acc = (acc + 1) >>> 1;
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      return acc[31:0];
    endfunction

    function void note_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic start);
      longint  t;
      int      n;
      vertex_t v;
      if (start) held = 0;
      for (int i = 0; i < 9; i++) win[i] = win[i + 3];
      win[9]  = longint'($signed(x));
      win[10] = longint'($signed(y));
      win[11] = longint'($signed(z));
      if (held < 4) held++;
      if (held < 4) return;
      t = 0;
      n = 0;
      while (t <= T_ONE && n < MAX_VERTS) begin
        v.x = blend_axis(0, t);
        v.y = blend_axis(1, t);
        v.z = blend_axis(2, t);
        v.last = (t + longint'(t_step) > T_ONE) || (n + 1 == MAX_VERTS);
        expected_q.push_back(v);
        n++;
        t += longint'(t_step);
      end
    endfunction

    function void check_vertex(logic [95:0] data, logic last);
      vertex_t e;
      if (expected_q.size() == 0) begin
        report("unexpected vertex", data[31:0], 32'h0);
        return;
      end
      e = expected_q.pop_front();
      if (data[31:0] !== e.x) report("vertex_x", data[31:0], e.x);
      if (data[63:32] !== e.y) report("vertex_y", data[63:32], e.y);
      if (data[95:64] !== e.z) report("vertex_z", data[95:64], e.z);
      if (last !== e.last) report("segment_last", {31'b0, last}, {31'b0, e.last});
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [95:0]                   s_axis_tdata;   // point_x, point_y, point_z
  logic                          s_axis_tuser;   // curve_start
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [95:0]                   m_axis_tdata;   // vertex_x, vertex_y, vertex_z
  logic                          m_axis_tlast;   // segment_last
  logic                          cfg_wr_en;
  logic [crct_pkg::T_STEP_W-1:0] cfg_wr_data;

  vertex_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  bit long_hold_req;
  bit long_hold_done;
  int hold_left;
  int quiet_cycles;

  catmull_rom_curve_tessellator_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom();
      // Mostly coordinates within a couple of hundred units, as real curves use.
      default: return 32'($urandom_range(26214400) - 32'd13107200);
    endcase
  endfunction

  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic start);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    s_axis_tuser <= start;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_point(x, y, z, start);
  endtask

  task automatic send_random_point(input logic start);
    send_point(rand_coord(), rand_coord(), rand_coord(), start);
  endtask

  // Stops offering points and waits until every owed vertex is out and the block has settled.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(input logic [crct_pkg::T_STEP_W-1:0] step);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= step;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.t_step = step;
  endtask

  // Vertex sink: checks each accepted vertex and throttles tready.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sb.check_vertex(m_axis_tdata, m_axis_tlast);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_catmull_rom_curve_tessellator_core: done, errors");
    $finish;
  end

  initial begin
    logic [crct_pkg::T_STEP_W-1:0] step;
    int                            count;
    sb = new();
    send_idle_pct = 21;
    recv_idle_pct = 45;
    long_hold_req = 1'b0;
    long_hold_done = 1'b0;
    hold_left = 0;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    m_axis_tready <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: curve start on an empty window, full-scale swings that saturate, a restart
    // in the middle of a curve, then the step extremes including zero, below minimum and
    // above one.
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 1'b0);
    send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 1'b1);
    send_point(32'h0002_0000, 32'h0003_0000, 32'h0000_8000, 1'b0);
    send_point(32'hFFFE_8000, 32'h0005_0000, 32'h7FFF_0000, 1'b0);
    send_point(32'h0004_0000, 32'hFFFB_0000, 32'h8001_0000, 1'b0);
    write_step(17'd65536);
    send_random_point(1'b0);
    send_random_point(1'b0);
    write_step(17'd0);
    send_random_point(1'b0);
    write_step(17'd1000);
    send_random_point(1'b0);
    write_step(17'd131071);
    send_random_point(1'b0);
    write_step(17'd1041);
    send_random_point(1'b0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 21;
        recv_idle_pct = 45;
      end else if (ph < 4) begin
        send_idle_pct = 45;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: begin step = crct_pkg::T_STEP_RESET; count = 75; end
        1: begin step = 17'($urandom_range(65536, 1041)); count = 75; end
        2: begin step = 17'd1041; count = 40; end
        3: begin step = 17'd65536; count = 75; end
        4: begin step = 17'($urandom_range(30000, 8000)); count = 80; end
        default: begin step = 17'($urandom_range(65536, 1041)); count = 75; end
      endcase
      write_step(step);
      for (int i = 0; i < count; i++) begin
        // The sink goes quiet for a long stretch while points keep coming.
        if (ph == 1 && i == 10) long_hold_req = 1'b1;
        send_random_point(i == 0 || $urandom_range(19) == 0);
      end
    end

    wait_drained();
    if (sb.errors == 0)
      $display("tb_catmull_rom_curve_tessellator_core: done, clean");
    else
      $display("tb_catmull_rom_curve_tessellator_core: done, errors");
    $finish;
  end

endmodule

FILE: files.f
design/crct_pkg.sv
design/crct_ctrl.sv
design/crct_dp.sv
design/catmull_rom_curve_tessellator_core.sv
dv/tb_catmull_rom_curve_tessellator_core.sv
